// ===== src/rrmp_pkg.sv =====
// ---------------------------------------------------------------------------
// rrmp_pkg: shared types and constants for the round-robin member pool
// Sizes of the member table, the remainder unit, and the command and status
// structs that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package rrmp_pkg;

  // table geometry
  localparam int MAX_MEMBERS = 16;
  localparam int ID_WIDTH    = 64;
  localparam int OUT_W       = 64;
  localparam int CTR_W       = 64;
  localparam int IDX_W       = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);

  // remainder unit: counter bits consumed per cycle
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = CTR_W / MOD_BITS;
  localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  // request codes
  typedef enum logic [1:0] {
    ACT_JOIN   = 2'd0,
    ACT_DEPART = 2'd1,
    ACT_NEXT   = 2'd2,
    ACT_NOP    = 2'd3
  } act_t;

  // result codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // table read address source
  typedef enum logic [1:0] {
    RD_SCAN = 2'd0,
    RD_UP   = 2'd1,
    RD_REM  = 2'd2
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan_step;
    logic    append;
    logic    shift_step;
    logic    remove;
    logic    mod_step;
    logic    pick;
    logic    finish;
    status_t fin_status;
    rd_sel_t rd_sel;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;
    logic scan_hit;
    logic full;
    logic empty;
    logic shift_last;
    logic mod_last;
  } dp_stat_t;

endpackage

// ===== src/rrmp_ctrl.sv =====
// ---------------------------------------------------------------------------
// rrmp_ctrl: request sequencer
// Takes a request, walks the search, shift, remainder and pick phases, and
// raises the result strobe for one cycle when the request completes.
// ---------------------------------------------------------------------------
module rrmp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rrmp_pkg::act_t    action,
  input  rrmp_pkg::dp_stat_t stat,
  output rrmp_pkg::dp_cmd_t cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_MOD,
    S_PICK
  } state_t;

  state_t         state;
  state_t         state_next;
  rrmp_pkg::act_t act_q;
  logic           accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    cmd            = '0;
    cmd.fin_status = rrmp_pkg::ST_OK;
    cmd.rd_sel     = rrmp_pkg::RD_SCAN;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          unique case (action) inside
            rrmp_pkg::ACT_JOIN, rrmp_pkg::ACT_DEPART: begin
              state_next = S_SEARCH;
            end
            rrmp_pkg::ACT_NEXT: begin
              if (stat.empty) begin
                cmd.finish     = 1'b1;
                cmd.fin_status = rrmp_pkg::ST_EMPTY;
              end else begin
                state_next = S_MOD;
              end
            end
            default: begin
              cmd.finish = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        cmd.rd_sel = rrmp_pkg::RD_SCAN;
        if (stat.scan_hit) begin
          if (act_q == rrmp_pkg::ACT_JOIN) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = rrmp_pkg::ST_PRESENT;
            state_next     = S_IDLE;
          end else begin
            state_next = S_SHIFT;
          end
        end else if (stat.scan_end) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
          if (act_q != rrmp_pkg::ACT_JOIN) begin
            cmd.fin_status = rrmp_pkg::ST_NOT_FOUND;
          end else if (stat.full) begin
            cmd.fin_status = rrmp_pkg::ST_FULL;
          end else begin
            cmd.append = 1'b1;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.rd_sel = rrmp_pkg::RD_UP;
        if (stat.shift_last) begin
          cmd.remove = 1'b1;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd.rd_sel = rrmp_pkg::RD_REM;
        cmd.pick   = 1'b1;
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state, request code and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
    if (accept) begin
      act_q <= action;
    end
  end

  // a taken request either completes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request taken but neither busy nor done");

  // the strobe always lands with the sequencer back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while still working");

endmodule

// ===== src/rrmp_dpath.sv =====
// ---------------------------------------------------------------------------
// rrmp_dpath: member table and arithmetic
// Holds the ordered member table, the count and the rotation counter, the
// scan index, and a radix-16 remainder unit for counter mod count.
// ---------------------------------------------------------------------------
module rrmp_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rrmp_pkg::OUT_W-1:0]    member_id,
  input  rrmp_pkg::dp_cmd_t             cmd,
  output rrmp_pkg::dp_stat_t            stat,
  output logic [2:0]                    status,
  output logic [rrmp_pkg::OUT_W-1:0]    chosen_id
);

  logic [rrmp_pkg::ID_WIDTH-1:0] member_table [rrmp_pkg::MAX_MEMBERS];
  logic [rrmp_pkg::ID_WIDTH-1:0] id_q;
  logic [rrmp_pkg::CNT_W-1:0]    idx;
  logic [rrmp_pkg::CNT_W-1:0]    idx_up;
  logic [rrmp_pkg::CNT_W-1:0]    count;
  logic [rrmp_pkg::CNT_W-1:0]    rem;
  logic [rrmp_pkg::CNT_W-1:0]    rem_next;
  logic [rrmp_pkg::CTR_W-1:0]    rot;
  logic [rrmp_pkg::CTR_W-1:0]    mod_sh;
  logic [rrmp_pkg::STEP_W-1:0]   step;
  logic [rrmp_pkg::IDX_W-1:0]    rd_addr;
  logic [rrmp_pkg::IDX_W-1:0]    wr_addr;
  logic [rrmp_pkg::ID_WIDTH-1:0] rd_data;
  rrmp_pkg::status_t             res_status;
  logic [rrmp_pkg::OUT_W-1:0]    res_id;

  // one long-division step per digit bit, remainder kept below count
  function automatic logic [rrmp_pkg::CNT_W-1:0] mod_digit(
    input logic [rrmp_pkg::CNT_W-1:0]    r_in,
    input logic [rrmp_pkg::MOD_BITS-1:0] digit,
    input logic [rrmp_pkg::CNT_W-1:0]    div
  );
    logic [rrmp_pkg::CNT_W-1:0] r;
    logic [rrmp_pkg::CNT_W:0]   t;
    r = r_in;
    for (int b = rrmp_pkg::MOD_BITS - 1; b >= 0; b--) begin
      t = {r, digit[b]};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
      r = t[rrmp_pkg::CNT_W-1:0];
    end
    return r;
  endfunction

  assign idx_up   = idx + rrmp_pkg::CNT_W'(1);
  assign rem_next = mod_digit(rem, mod_sh[rrmp_pkg::CTR_W-1 -: rrmp_pkg::MOD_BITS], count);

  // single table read port
  always_comb begin
    case (cmd.rd_sel)
      rrmp_pkg::RD_UP:  rd_addr = idx_up[rrmp_pkg::IDX_W-1:0];
      rrmp_pkg::RD_REM: rd_addr = rem[rrmp_pkg::IDX_W-1:0];
      default:          rd_addr = idx[rrmp_pkg::IDX_W-1:0];
    endcase
  end
  assign rd_data = member_table[rd_addr];

  // single table write port
  assign wr_addr = cmd.append ? count[rrmp_pkg::IDX_W-1:0] : idx[rrmp_pkg::IDX_W-1:0];

  // status back to the controller
  assign stat.scan_end   = (idx == count);
  assign stat.scan_hit   = (idx != count) && (rd_data == id_q);
  assign stat.full       = (count == rrmp_pkg::CNT_W'(rrmp_pkg::MAX_MEMBERS));
  assign stat.empty      = (count == '0);
  assign stat.shift_last = (idx_up >= count);
  assign stat.mod_last   = (step == rrmp_pkg::STEP_W'(rrmp_pkg::MOD_STEPS - 1));

  // table writes: append at the tail or close the gap
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      member_table[wr_addr] <= id_q;
    end else if (cmd.shift_step) begin
      member_table[wr_addr] <= rd_data;
    end
  end

  // count and rotation counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rot   <= '0;
    end else begin
      if (cmd.append) begin
        count <= count + rrmp_pkg::CNT_W'(1);
      end else if (cmd.remove) begin
        count <= count - rrmp_pkg::CNT_W'(1);
      end
      if (cmd.pick) begin
        rot <= rot + rrmp_pkg::CTR_W'(1);
      end
    end
  end

  // request operands, scan index and remainder unit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_q   <= member_id[rrmp_pkg::ID_WIDTH-1:0];
      idx    <= '0;
      rem    <= '0;
      mod_sh <= rot;
      step   <= '0;
    end else begin
      if (cmd.scan_step || cmd.shift_step) begin
        idx <= idx_up;
      end
      if (cmd.mod_step) begin
        rem    <= rem_next;
        mod_sh <= mod_sh << rrmp_pkg::MOD_BITS;
        step   <= step + rrmp_pkg::STEP_W'(1);
      end
    end
  end

  // result registers, loaded on the finishing transfer
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status <= cmd.fin_status;
      res_id     <= cmd.pick ? rrmp_pkg::OUT_W'(rd_data) : '0;
    end
  end

  assign status    = res_status;
  assign chosen_id = res_id;

  // the selected slot is always a live entry
  a_pick_range: assert property (@(posedge clk) disable iff (rst)
    cmd.pick |-> (rem < count))
    else $error("selection index beyond member count");

  // appending only into a table with room
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (count < rrmp_pkg::CNT_W'(rrmp_pkg::MAX_MEMBERS)))
    else $error("append into a full table");

  // compaction only reads live entries
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_step |-> (idx_up < count))
    else $error("shift reads past the last member");

endmodule

// ===== src/round_robin_member_pool.sv =====
// ---------------------------------------------------------------------------
// round_robin_member_pool: ordered pool of distinct ids, round-robin pick
// Join scans, and depart scans then shifts, one entry a cycle; next works
//   through the 4-bit-a-cycle counter remainder, then reads the table; each
//   reply is registered. Empty next and the unused code finish from idle.
//   One request at a time, a new start is taken in the done cycle. The
//   receiver cannot stall.
// Reset (rst, synchronous) empties the pool and zeroes the rotation counter.
// ---------------------------------------------------------------------------
module round_robin_member_pool (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 action,
  input  logic [rrmp_pkg::OUT_W-1:0] member_id,
  output logic                       done,
  output logic [2:0]                 status,
  output logic [rrmp_pkg::OUT_W-1:0] chosen_id
);

  rrmp_pkg::dp_cmd_t  cmd;
  rrmp_pkg::dp_stat_t stat;

  // sequencer
  rrmp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (rrmp_pkg::act_t'(action)),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // table, counters and remainder unit
  rrmp_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .member_id (member_id),
    .cmd       (cmd),
    .stat      (stat),
    .status    (status),
    .chosen_id (chosen_id)
  );

endmodule

// ===== bench/member_pool_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// member_pool_checker: scoreboard for the round-robin member pool
// Watches the request and reply channels, keeps its own copy of the member
// table and rotation counter, works out the reply owed for every accepted
// request and compares each done strobe with the oldest reply still owed.
// ---------------------------------------------------------------------------
module member_pool_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 action,
  input  logic [rrmp_pkg::OUT_W-1:0] member_id,
  input  logic                       done,
  input  logic [2:0]                 status,
  input  logic [rrmp_pkg::OUT_W-1:0] chosen_id,
  output int                         fail_count,
  output int                         outstanding,
  output int                         replies_checked,
  output int                         full_refusals
);

  typedef struct packed {
    rrmp_pkg::status_t          st;
    logic [rrmp_pkg::OUT_W-1:0] id;
  } pool_reply_t;

  // shadow copy of the pool
  logic [rrmp_pkg::ID_WIDTH-1:0] shadow_ids [rrmp_pkg::MAX_MEMBERS];
  int unsigned                   shadow_count = 0;
  logic [rrmp_pkg::CTR_W-1:0]    shadow_rotation = '0;

  // replies owed, oldest first
  pool_reply_t owed_replies [$];
  pool_reply_t oldest;
  pool_reply_t fresh;

  int mismatches = 0;
  int checked    = 0;
  int full_seen  = 0;

  // apply one request to the shadow pool and work out its reply
  task automatic apply_pool_request(input rrmp_pkg::act_t req,
                                    input logic [rrmp_pkg::OUT_W-1:0] raw_id,
                                    output pool_reply_t reply);
    logic [rrmp_pkg::ID_WIDTH-1:0] key;
    logic [rrmp_pkg::CTR_W-1:0]    divisor;
    logic [rrmp_pkg::CTR_W-1:0]    slot;
    int                            hit;
    key      = raw_id[rrmp_pkg::ID_WIDTH-1:0];
    reply.st = rrmp_pkg::ST_OK;
    reply.id = '0;
    hit      = -1;
    for (int i = 0; i < shadow_count; i++)
      if (hit < 0 && shadow_ids[i] == key) hit = i;
    case (req)
      rrmp_pkg::ACT_JOIN: begin
        // presence wins over a full table
        if (hit >= 0) reply.st = rrmp_pkg::ST_PRESENT;
        else if (shadow_count >= rrmp_pkg::MAX_MEMBERS) reply.st = rrmp_pkg::ST_FULL;
        else begin
          shadow_ids[shadow_count] = key;
          shadow_count++;
        end
      end
      rrmp_pkg::ACT_DEPART: begin
        // close the gap so later members keep their order
        if (hit < 0) reply.st = rrmp_pkg::ST_NOT_FOUND;
        else begin
          for (int i = hit; i + 1 < shadow_count; i++) shadow_ids[i] = shadow_ids[i + 1];
          shadow_count--;
        end
      end
      rrmp_pkg::ACT_NEXT: begin
        if (shadow_count == 0) reply.st = rrmp_pkg::ST_EMPTY;
        else begin
          divisor  = rrmp_pkg::CTR_W'(shadow_count);
          slot     = shadow_rotation % divisor;
          reply.id = shadow_ids[slot];
          shadow_rotation++;
        end
      end
      default: ;
    endcase
  endtask

  // compare replies, then log the request taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      shadow_count    = 0;
      shadow_rotation = '0;
      owed_replies.delete();
    end else begin
      if (done) begin
        if (owed_replies.size() == 0) begin
          $error("reply with nothing owed: status %0d chosen_id %h", status, chosen_id);
          mismatches++;
        end else begin
          oldest = owed_replies.pop_front();
          if (status !== oldest.st) begin
            $error("status: expected %0d, got %0d", oldest.st, status);
            mismatches++;
          end
          if (chosen_id !== oldest.id) begin
            $error("chosen_id: expected %h, got %h", oldest.id, chosen_id);
            mismatches++;
          end
          checked++;
          if (oldest.st == rrmp_pkg::ST_FULL) full_seen++;
        end
      end
      if (start && !busy) begin
        apply_pool_request(rrmp_pkg::act_t'(action), member_id, fresh);
        owed_replies.push_back(fresh);
      end
    end
    fail_count      <= mismatches;
    outstanding     <= owed_replies.size();
    replies_checked <= checked;
    full_refusals   <= full_seen;
  end

endmodule

// ===== bench/round_robin_member_pool_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// round_robin_member_pool_test: request generator for the member pool
// Runs a short directed sequence over the empty, full and refusal cases, then
// random joins, departs and picks in growing, shrinking and churning phases,
// with random idle gaps; a separate scoreboard checks every reply.
// ---------------------------------------------------------------------------
module round_robin_member_pool_test;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1400;
  localparam int POOL_IDS     = 24;
  localparam int TAIL_CYCLES  = 40;

  // random traffic mix
  typedef enum logic [1:0] {
    PH_GROW,
    PH_SHRINK,
    PH_CHURN
  } load_phase_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       start     = 1'b0;
  logic [1:0]                 action    = rrmp_pkg::ACT_NOP;
  logic [rrmp_pkg::OUT_W-1:0] member_id = '0;
  logic                       busy;
  logic                       done;
  logic [2:0]                 status;
  logic [rrmp_pkg::OUT_W-1:0] chosen_id;

  int fail_count;
  int outstanding;
  int replies_checked;
  int full_refusals;
  int cycle_count;
  int sent [4];

  logic                       idle_free = 1'b0;
  logic [rrmp_pkg::OUT_W-1:0] id_pool [POOL_IDS];

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  round_robin_member_pool uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .member_id (member_id),
    .done      (done),
    .status    (status),
    .chosen_id (chosen_id)
  );

  member_pool_checker pool_watch (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .member_id       (member_id),
    .done            (done),
    .status          (status),
    .chosen_id       (chosen_id),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .replies_checked (replies_checked),
    .full_refusals   (full_refusals)
  );

  function automatic logic [rrmp_pkg::OUT_W-1:0] fresh_id();
    return {$urandom, $urandom};
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (idle_free) return 0;
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // one request transfer, then an optional idle gap
  task automatic issue(input rrmp_pkg::act_t req, input logic [rrmp_pkg::OUT_W-1:0] id);
    int gap;
    gap = idle_gap();
    start     <= 1'b1;
    action    <= req;
    member_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent[req]++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int                         phase_left;
    int                         roll;
    int                         join_lim;
    int                         depart_lim;
    rrmp_pkg::act_t             req;
    logic [rrmp_pkg::OUT_W-1:0] pick;
    load_phase_t                phase_kind;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pool, unused code, id extremes, duplicates
    issue(rrmp_pkg::ACT_NEXT, '1);
    issue(rrmp_pkg::ACT_DEPART, '0);
    issue(rrmp_pkg::ACT_NOP, '1);
    issue(rrmp_pkg::ACT_JOIN, '0);
    issue(rrmp_pkg::ACT_JOIN, '1);
    issue(rrmp_pkg::ACT_JOIN, '1);
    issue(rrmp_pkg::ACT_NEXT, '0);
    issue(rrmp_pkg::ACT_DEPART, '0);
    issue(rrmp_pkg::ACT_DEPART, 64'h5555_5555_5555_5555);
    // fill the table, then refuse a newcomer and a member already present
    for (int k = 0; k < rrmp_pkg::MAX_MEMBERS - 1; k++) issue(rrmp_pkg::ACT_JOIN, fresh_id());
    issue(rrmp_pkg::ACT_JOIN, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(rrmp_pkg::ACT_JOIN, '1);
    issue(rrmp_pkg::ACT_NEXT, '1);

    // random phases over a small id pool so hits and refusals are common
    for (int k = 0; k < POOL_IDS; k++) id_pool[k] = fresh_id();
    id_pool[0] = '0;
    id_pool[1] = '1;
    phase_left = 0;
    phase_kind = PH_CHURN;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_kind = load_phase_t'($urandom_range(0, 2));
        phase_left = $urandom_range(30, 90);
        idle_free  = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      if ($urandom_range(0, 99) < 3) id_pool[$urandom_range(0, POOL_IDS - 1)] = fresh_id();
      case (phase_kind)
        PH_GROW: begin
          join_lim   = 60;
          depart_lim = 75;
        end
        PH_SHRINK: begin
          join_lim   = 15;
          depart_lim = 75;
        end
        default: begin
          join_lim   = 30;
          depart_lim = 60;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < join_lim) req = rrmp_pkg::ACT_JOIN;
      else if (roll < depart_lim) req = rrmp_pkg::ACT_DEPART;
      else if (roll < 95) req = rrmp_pkg::ACT_NEXT;
      else req = rrmp_pkg::ACT_NOP;
      pick = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL_IDS - 1)]
                                          : fresh_id();
      issue(req, pick);
    end

    // drain and let any stray reply show up
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests sent: %0d join, %0d depart, %0d next, %0d unused code",
             sent[rrmp_pkg::ACT_JOIN] + sent[rrmp_pkg::ACT_DEPART] +
             sent[rrmp_pkg::ACT_NEXT] + sent[rrmp_pkg::ACT_NOP],
             sent[rrmp_pkg::ACT_JOIN], sent[rrmp_pkg::ACT_DEPART],
             sent[rrmp_pkg::ACT_NEXT], sent[rrmp_pkg::ACT_NOP]);
    $display("%0d replies compared, %0d of them full-table refusals",
             replies_checked, full_refusals);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
